// File: hdl/spq_pkg.sv
package spq_pkg;

  localparam int QUEUE_DEPTH = 16;
  localparam int CNT_W       = $clog2(QUEUE_DEPTH + 1);
  localparam int DATA_W      = 32;
  localparam int PRIO_W      = 16;
  localparam int OCC_W       = 5;
  localparam int STAT_W      = 2;
  localparam int IN_TDATA_W  = 48;
  localparam int OUT_TDATA_W = 56;

  typedef enum logic [STAT_W-1:0] {
    ST_OK    = 2'd0,
    ST_EMPTY = 2'd1,
    ST_FULL  = 2'd2
  } status_t;

  typedef enum logic {
    FN_ENQ = 1'b0,
    FN_DEQ = 1'b1
  } func_t;

  typedef struct packed {
    logic enq;
    logic deq;
    logic valid;
    logic left_gt;
  } cell_ctl_t;

endpackage

// File: hdl/spq_cell.sv
module spq_cell (
  input  logic                      clk,
  input  spq_pkg::cell_ctl_t        ctl,
  input  logic [spq_pkg::DATA_W-1:0] new_data,
  input  logic [spq_pkg::PRIO_W-1:0] new_prio,
  input  logic [spq_pkg::DATA_W-1:0] left_data,
  input  logic [spq_pkg::PRIO_W-1:0] left_prio,
  input  logic [spq_pkg::DATA_W-1:0] right_data,
  input  logic [spq_pkg::PRIO_W-1:0] right_prio,
  output logic [spq_pkg::DATA_W-1:0] data,
  output logic [spq_pkg::PRIO_W-1:0] prio,
  output logic                      gt
);
  import spq_pkg::*;

  logic [DATA_W-1:0] data_r, data_nxt;
  logic [PRIO_W-1:0] prio_r, prio_nxt;

  // at or behind the insert point
  assign gt = !ctl.valid || (prio_r > new_prio);

  always_comb begin
    data_nxt = data_r;
    prio_nxt = prio_r;
    if (ctl.enq && gt) begin
      if (ctl.left_gt) begin
        data_nxt = left_data;
        prio_nxt = left_prio;
      end else begin
        data_nxt = new_data;
        prio_nxt = new_prio;
      end
    end else if (ctl.deq) begin
      data_nxt = right_data;
      prio_nxt = right_prio;
    end
  end

  always_ff @(posedge clk) begin
    data_r <= data_nxt;
    prio_r <= prio_nxt;
  end

  assign data = data_r;
  assign prio = prio_r;

endmodule

// File: hdl/sorted_priority_queue.sv
// Channel | Direction | tdata (low bit up)                      | tuser
// in_     | slave     | in_data[31:0], in_priority[47:32]       | func[0]
// out_    | master    | out_data[31:0], out_priority[47:32],    | status[1:0]
//         |           | occupancy[52:48], zero fill [55:53]     |
// One request per cycle unless output stalls; its result is in the output
// register in the cycle after acceptance, as the cell row compare-and-shifts.
// rst_n (synchronous) empties the queue and the output register.
// A stalled result holds; a new request is taken when the output is empty
// or being taken in the same cycle.
module sorted_priority_queue (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_tvalid,
  output logic        in_tready,
  input  logic [47:0] in_tdata,  // in_data, in_priority
  input  logic [0:0]  in_tuser,  // func
  output logic        out_tvalid,
  input  logic        out_tready,
  output logic [55:0] out_tdata, // out_data, out_priority, occupancy
  output logic [1:0]  out_tuser  // status
);
  import spq_pkg::*;

  logic [CNT_W-1:0]  count_r, count_nxt;
  logic              out_valid_r, out_valid_nxt;
  logic [DATA_W-1:0] res_data_r, res_data_nxt;
  logic [PRIO_W-1:0] res_prio_r, res_prio_nxt;
  logic [OCC_W-1:0]  res_occ_r, res_occ_nxt;
  status_t           res_stat_r, res_stat_nxt;

  logic              accept;
  func_t             fn;
  logic [DATA_W-1:0] req_data;
  logic [PRIO_W-1:0] req_prio;
  logic              full, empty, do_enq, do_deq;
  logic [OCC_W+CNT_W-1:0] occ_wide;

  logic [DATA_W-1:0] cell_data [QUEUE_DEPTH];
  logic [PRIO_W-1:0] cell_prio [QUEUE_DEPTH];
  logic [QUEUE_DEPTH-1:0] cell_gt;

  assign in_tready = !out_valid_r || out_tready;
  assign accept    = in_tvalid && in_tready;
  assign fn        = func_t'(in_tuser[0]);
  assign req_data  = in_tdata[DATA_W-1:0];
  assign req_prio  = in_tdata[DATA_W+PRIO_W-1:DATA_W];
  assign full      = (count_r == CNT_W'(QUEUE_DEPTH));
  assign empty     = (count_r == '0);
  assign do_enq    = accept && (fn == FN_ENQ) && !full;
  assign do_deq    = accept && (fn == FN_DEQ) && !empty;

  genvar i;
  generate
    for (i = 0; i < QUEUE_DEPTH; i++) begin : g_cell
      cell_ctl_t         ctl;
      logic [DATA_W-1:0] l_data, r_data;
      logic [PRIO_W-1:0] l_prio, r_prio;

      assign ctl.enq   = do_enq;
      assign ctl.deq   = do_deq;
      assign ctl.valid = (CNT_W'(i) < count_r);

      if (i == 0) begin : g_head
        assign ctl.left_gt = 1'b0;
        assign l_data = '0;
        assign l_prio = '0;
      end else begin : g_mid
        assign ctl.left_gt = cell_gt[i-1];
        assign l_data = cell_data[i-1];
        assign l_prio = cell_prio[i-1];
      end

      if (i == QUEUE_DEPTH - 1) begin : g_tail
        assign r_data = '0;
        assign r_prio = '0;
      end else begin : g_body
        assign r_data = cell_data[i+1];
        assign r_prio = cell_prio[i+1];
      end

      spq_cell u_cell (
        .clk        (clk),
        .ctl        (ctl),
        .new_data   (req_data),
        .new_prio   (req_prio),
        .left_data  (l_data),
        .left_prio  (l_prio),
        .right_data (r_data),
        .right_prio (r_prio),
        .data       (cell_data[i]),
        .prio       (cell_prio[i]),
        .gt         (cell_gt[i])
      );
    end
  endgenerate

  always_comb begin
    count_nxt     = count_r;
    out_valid_nxt = out_valid_r;
    res_data_nxt  = res_data_r;
    res_prio_nxt  = res_prio_r;
    res_stat_nxt  = res_stat_r;
    if (out_valid_r && out_tready) begin
      out_valid_nxt = 1'b0;
    end
    if (do_enq) begin
      count_nxt = count_r + CNT_W'(1);
    end else if (do_deq) begin
      count_nxt = count_r - CNT_W'(1);
    end
    if (accept) begin
      out_valid_nxt = 1'b1;
      res_data_nxt  = '0;
      res_prio_nxt  = '0;
      res_stat_nxt  = ST_OK;
      case (fn)
        FN_ENQ: begin
          if (full) begin
            res_stat_nxt = ST_FULL;
          end
        end
        FN_DEQ: begin
          if (empty) begin
            res_stat_nxt = ST_EMPTY;
          end else begin
            res_data_nxt = cell_data[0];
            res_prio_nxt = cell_prio[0];
          end
        end
        default: begin
          res_stat_nxt = ST_OK;
        end
      endcase
    end
  end

  assign occ_wide    = {{OCC_W{1'b0}}, count_nxt};
  assign res_occ_nxt = accept ? occ_wide[OCC_W-1:0] : res_occ_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      count_r     <= '0;
      out_valid_r <= 1'b0;
    end else begin
      count_r     <= count_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    res_data_r <= res_data_nxt;
    res_prio_r <= res_prio_nxt;
    res_occ_r  <= res_occ_nxt;
    res_stat_r <= res_stat_nxt;
  end

  assign out_tvalid = out_valid_r;
  assign out_tdata  = {3'b000, res_occ_r, res_prio_r, res_data_r};
  assign out_tuser  = res_stat_r;

endmodule

// File: bench/tb_sorted_priority_queue.sv
module tb_sorted_priority_queue;
  timeunit 1ns;
  timeprecision 1ps;

  import spq_pkg::*;

  localparam int CYCLE_LIMIT = 400000;

  typedef struct {
    status_t           status;
    logic [DATA_W-1:0] data;
    logic [PRIO_W-1:0] prio;
    logic [OCC_W-1:0]  occupancy;
  } queue_result_t;

  logic        clk;
  logic        rst_n;
  logic        in_tvalid;
  logic        in_tready;
  logic [47:0] in_tdata;   // in_data[31:0], in_priority[47:32]
  logic [0:0]  in_tuser;   // func[0]
  logic        out_tvalid;
  logic        out_tready;
  logic [55:0] out_tdata;  // out_data[31:0], out_priority[47:32], occupancy[52:48]
  logic [1:0]  out_tuser;  // status[1:0]

  logic [DATA_W-1:0] held_data [QUEUE_DEPTH];
  logic [PRIO_W-1:0] held_prio [QUEUE_DEPTH];
  int                held_count = 0;

  queue_result_t predicted_results[$];
  int            error_count = 0;
  int            cycle_count = 0;
  bit            tx_idle = 1'b1;
  bit            rx_idle = 1'b1;
  int            rx_hold_request = 0;

  sorted_priority_queue dut (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .in_tdata   (in_tdata),
    .in_tuser   (in_tuser),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata),
    .out_tuser  (out_tuser)
  );

  initial begin
    clk = 1'b0;
    forever #4 clk = ~clk;
  end

  initial begin
    forever begin
      @(posedge clk);
      cycle_count++;
      if (cycle_count > CYCLE_LIMIT) begin
        $display("DONE: errors detected");
        $finish;
      end
    end
  end

  function automatic queue_result_t apply_queue_op(func_t op, logic [DATA_W-1:0] data,
                                                   logic [PRIO_W-1:0] prio);
    queue_result_t res;
    int            pos;
    res.status = ST_OK;
    res.data   = '0;
    res.prio   = '0;
    if (op == FN_ENQ) begin
      if (held_count >= QUEUE_DEPTH) begin
        res.status = ST_FULL;
      end else begin
        pos = 0;
        while (pos < held_count && held_prio[pos] <= prio) pos++;
        for (int i = held_count; i > pos; i--) begin
          held_data[i] = held_data[i-1];
          held_prio[i] = held_prio[i-1];
        end
        held_data[pos] = data;
        held_prio[pos] = prio;
        held_count++;
      end
    end else begin
      if (held_count == 0) begin
        res.status = ST_EMPTY;
      end else begin
        res.data = held_data[0];
        res.prio = held_prio[0];
        for (int i = 1; i < held_count; i++) begin
          held_data[i-1] = held_data[i];
          held_prio[i-1] = held_prio[i];
        end
        held_count--;
      end
    end
    res.occupancy = held_count[OCC_W-1:0];
    return res;
  endfunction

  task automatic flag_mismatch(string what, logic [31:0] want, logic [31:0] got);
    error_count++;
    if (error_count <= 10)
      $display("[%0t] %s mismatch: expected %h, got %h", $realtime, what, want, got);
  endtask

  // result checker
  initial begin
    queue_result_t want;
    forever begin
      @(posedge clk);
      if (rst_n && out_tvalid && out_tready) begin
        if (predicted_results.size() == 0) begin
          error_count++;
          if (error_count <= 10)
            $display("[%0t] result with no request pending: tdata %h tuser %h",
                     $realtime, out_tdata, out_tuser);
        end else begin
          want = predicted_results.pop_front();
          if (out_tuser != want.status)
            flag_mismatch("status", 32'(want.status), 32'(out_tuser));
          if (out_tdata[31:0] != want.data)
            flag_mismatch("data", want.data, out_tdata[31:0]);
          if (out_tdata[47:32] != want.prio)
            flag_mismatch("priority", 32'(want.prio), 32'(out_tdata[47:32]));
          if (out_tdata[52:48] != want.occupancy)
            flag_mismatch("occupancy", 32'(want.occupancy), 32'(out_tdata[52:48]));
        end
      end
    end
  end

  // result receiver: random stalls plus requested long hold-offs
  initial begin
    int stall;
    stall = 0;
    out_tready <= 1'b0;
    forever begin
      @(posedge clk);
      if (out_tvalid && out_tready)
        stall = rx_idle ? $urandom_range(0, 10) : 0;
      if (rx_hold_request != 0) begin
        stall = rx_hold_request;
        rx_hold_request = 0;
      end
      if (stall > 0) begin
        out_tready <= 1'b0;
        stall--;
      end else begin
        out_tready <= 1'b1;
      end
    end
  end

  task automatic send_request(func_t op, logic [DATA_W-1:0] data, logic [PRIO_W-1:0] prio);
    int gap;
    gap = tx_idle ? $urandom_range(0, 10) : 0;
    if (gap != 0) begin
      in_tvalid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_tvalid <= 1'b1;
    in_tdata  <= {prio, data};
    in_tuser  <= op;
    do @(posedge clk); while (!in_tready);
    predicted_results.push_back(apply_queue_op(op, data, prio));
  endtask

  task automatic wait_for_drain();
    in_tvalid <= 1'b0;
    while (predicted_results.size() != 0) @(posedge clk);
  endtask

  function automatic logic [PRIO_W-1:0] pick_priority();
    case ($urandom_range(0, 3))
      0:       return PRIO_W'($urandom_range(0, 3));
      1:       return $urandom_range(0, 1) ? '1 : '0;
      default: return PRIO_W'($urandom);
    endcase
  endfunction

  task automatic send_random(int enq_pct);
    func_t op;
    op = ($urandom_range(1, 100) <= enq_pct) ? FN_ENQ : FN_DEQ;
    send_request(op, $urandom, pick_priority());
  endtask

  task automatic test_directed();
    send_request(FN_DEQ, 32'hFFFF_FFFF, 16'hFFFF);
    send_request(FN_ENQ, 32'h7FFF_FFFF, 16'hFFFF);
    send_request(FN_ENQ, 32'h8000_0000, 16'h0000);
    send_request(FN_ENQ, 32'h0000_0000, 16'h8000);
    send_request(FN_ENQ, 32'hFFFF_FFFF, 16'h0000);
    send_request(FN_ENQ, 32'h5555_5555, 16'hFFFF);
    send_request(FN_ENQ, 32'hAAAA_AAAA, 16'h1234);
    send_request(FN_ENQ, 32'h0000_0001, 16'h8000);
    repeat (8) send_request(FN_DEQ, $urandom, PRIO_W'($urandom));
  endtask

  task automatic test_full_queue();
    repeat (QUEUE_DEPTH) send_request(FN_ENQ, $urandom, pick_priority());
    send_request(FN_ENQ, 32'h7FFF_FFFF, 16'h0000);
    send_request(FN_ENQ, 32'h8000_0000, 16'hFFFF);
    repeat (QUEUE_DEPTH + 1) send_request(FN_DEQ, $urandom, PRIO_W'($urandom));
  endtask

  task automatic test_random_mix();
    int enq_pct;
    for (int seg = 0; seg < 12; seg++) begin
      case (seg % 4)
        0:       enq_pct = 80;
        1:       enq_pct = 50;
        2:       enq_pct = 20;
        default: enq_pct = 60;
      endcase
      tx_idle = (seg % 2) == 1;
      rx_idle = ((seg / 2) % 2) == 1;
      repeat (105) send_random(enq_pct);
    end
    tx_idle = 1'b1;
    rx_idle = 1'b1;
  endtask

  task automatic test_backpressure();
    tx_idle = 1'b0;
    rx_hold_request = 300;
    repeat (40) send_random(70);
    tx_idle = 1'b1;
  endtask

  task automatic test_drain_pause();
    repeat (5) send_random(60);
    wait_for_drain();
    repeat (5) send_random(40);
  endtask

  initial begin
    rst_n     <= 1'b0;
    in_tvalid <= 1'b0;
    in_tdata  <= '0;
    in_tuser  <= '0;
    repeat (2) @(posedge clk);
    rst_n <= 1'b1;
    test_directed();
    test_full_queue();
    test_random_mix();
    test_backpressure();
    test_drain_pause();
    wait_for_drain();
    repeat (4) @(posedge clk);
    if (error_count == 0) begin
      $display("DONE: 0 errors");
    end else begin
      $display("DONE: errors detected");
    end
    $finish;
  end

endmodule
